[sv/msgpk_pkg.sv]
package msgpk_pkg;

  typedef enum logic [2:0] {
    KIND_UINT  = 3'd0,
    KIND_MAP   = 3'd1,
    KIND_STR   = 3'd2,
    KIND_BIN   = 3'd3,
    KIND_NIL   = 3'd4,
    KIND_BOOL  = 3'd5,
    KIND_BYTE  = 3'd6,
    KIND_ERROR = 3'd7
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_UNSUPPORTED = 2'd1,
    ERR_TRUNCATED   = 2'd2
  } err_code_e;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'b001,
    PH_GATHER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  // Type bytes outside the fixint, fixmap and fixstr ranges
  localparam logic [7:0] TB_NIL    = 8'hc0;
  localparam logic [7:0] TB_FALSE  = 8'hc2;
  localparam logic [7:0] TB_TRUE   = 8'hc3;
  localparam logic [7:0] TB_BIN8   = 8'hc4;
  localparam logic [7:0] TB_BIN16  = 8'hc5;
  localparam logic [7:0] TB_BIN32  = 8'hc6;
  localparam logic [7:0] TB_UINT8  = 8'hcc;
  localparam logic [7:0] TB_UINT16 = 8'hcd;
  localparam logic [7:0] TB_UINT32 = 8'hce;
  localparam logic [7:0] TB_UINT64 = 8'hcf;
  localparam logic [7:0] TB_STR8   = 8'hd9;
  localparam logic [7:0] TB_STR16  = 8'hda;
  localparam logic [7:0] TB_STR32  = 8'hdb;
  localparam logic [7:0] TB_MAP16  = 8'hde;
  localparam logic [7:0] TB_MAP32  = 8'hdf;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    tok_kind_e   token_kind;
    logic [63:0] token_value;
    logic        payload_last;
    err_code_e   error_code;
  } out_word_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] bytes_left;
    logic [63:0] gathered;
    logic [1:0]  pending_kind;
    logic        dropping;
  } tok_state_t;

  localparam tok_state_t TOK_STATE_RESET = '{
    phase:        PH_TYPE,
    bytes_left:   32'd0,
    gathered:     64'd0,
    pending_kind: 2'd0,
    dropping:     1'b0
  };

endpackage

[sv/msgpk_step.sv]
module msgpk_step
  import msgpk_pkg::*;
(
  input  tok_state_t state_i,
  input  in_word_t   word_i,
  output tok_state_t state_o,
  output logic       res_valid_o,
  output out_word_t  res_o
);

  logic [7:0]  t;
  logic        fend;
  logic [63:0] gv_shift;
  logic [31:0] bl_dec;
  logic        do_finish;
  tok_kind_e   fin_kind;
  logic [63:0] fin_value;
  logic        do_fail;
  err_code_e   fail_code;
  logic        do_gather;
  tok_kind_e   g_kind;
  logic [3:0]  g_count;

  assign t        = word_i.frame_byte;
  assign fend     = word_i.frame_end;
  assign gv_shift = {state_i.gathered[55:0], t};
  assign bl_dec   = (state_i.bytes_left != 32'd0) ? state_i.bytes_left - 32'd1 : 32'd0;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{token_kind: KIND_UINT, token_value: 64'd0, payload_last: 1'b0,
                    error_code: ERR_NONE};
    do_finish   = 1'b0;
    fin_kind    = KIND_UINT;
    fin_value   = 64'd0;
    do_fail     = 1'b0;
    fail_code   = ERR_NONE;
    do_gather   = 1'b0;
    g_kind      = KIND_UINT;
    g_count     = 4'd0;

    if (state_i.dropping) begin
      // drop until the end of the frame
      if (fend) begin
        state_o = TOK_STATE_RESET;
      end
    end else begin
      unique case (state_i.phase)
        PH_GATHER: begin
          state_o.gathered   = gv_shift;
          state_o.bytes_left = bl_dec;
          if (bl_dec != 32'd0) begin
            if (fend) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end
          end else begin
            do_finish = 1'b1;
            fin_kind  = tok_kind_e'({1'b0, state_i.pending_kind});
            fin_value = gv_shift;
          end
        end
        PH_PAYLOAD: begin
          state_o.bytes_left = bl_dec;
          if (bl_dec == 32'd0) begin
            state_o.phase = PH_TYPE;
            res_valid_o   = 1'b1;
            res_o.token_kind   = KIND_BYTE;
            res_o.token_value  = {56'd0, t};
            res_o.payload_last = 1'b1;
          end else if (fend) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            res_valid_o       = 1'b1;
            res_o.token_kind  = KIND_BYTE;
            res_o.token_value = {56'd0, t};
          end
        end
        default: begin
          priority if (!t[7]) begin
            do_finish = 1'b1;
            fin_kind  = KIND_UINT;
            fin_value = {56'd0, t};
          end else if (t[7:4] == 4'h8) begin
            do_finish = 1'b1;
            fin_kind  = KIND_MAP;
            fin_value = {60'd0, t[3:0]};
          end else if (t[7:5] == 3'b101) begin
            do_finish = 1'b1;
            fin_kind  = KIND_STR;
            fin_value = {59'd0, t[4:0]};
          end else if (t == TB_NIL) begin
            res_valid_o      = 1'b1;
            res_o.token_kind = KIND_NIL;
          end else if (t == TB_FALSE || t == TB_TRUE) begin
            res_valid_o       = 1'b1;
            res_o.token_kind  = KIND_BOOL;
            res_o.token_value = {63'd0, t[0]};
          end else if (t == TB_BIN8) begin
            do_gather = 1'b1; g_kind = KIND_BIN;  g_count = 4'd1;
          end else if (t == TB_BIN16) begin
            do_gather = 1'b1; g_kind = KIND_BIN;  g_count = 4'd2;
          end else if (t == TB_BIN32) begin
            do_gather = 1'b1; g_kind = KIND_BIN;  g_count = 4'd4;
          end else if (t == TB_UINT8) begin
            do_gather = 1'b1; g_kind = KIND_UINT; g_count = 4'd1;
          end else if (t == TB_UINT16) begin
            do_gather = 1'b1; g_kind = KIND_UINT; g_count = 4'd2;
          end else if (t == TB_UINT32) begin
            do_gather = 1'b1; g_kind = KIND_UINT; g_count = 4'd4;
          end else if (t == TB_UINT64) begin
            do_gather = 1'b1; g_kind = KIND_UINT; g_count = 4'd8;
          end else if (t == TB_STR8) begin
            do_gather = 1'b1; g_kind = KIND_STR;  g_count = 4'd1;
          end else if (t == TB_STR16) begin
            do_gather = 1'b1; g_kind = KIND_STR;  g_count = 4'd2;
          end else if (t == TB_STR32) begin
            do_gather = 1'b1; g_kind = KIND_STR;  g_count = 4'd4;
          end else if (t == TB_MAP16) begin
            do_gather = 1'b1; g_kind = KIND_MAP;  g_count = 4'd2;
          end else if (t == TB_MAP32) begin
            do_gather = 1'b1; g_kind = KIND_MAP;  g_count = 4'd4;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_UNSUPPORTED;
          end
        end
      endcase

      if (do_gather) begin
        if (fend) begin
          do_fail   = 1'b1;
          fail_code = ERR_TRUNCATED;
        end else begin
          state_o.phase        = PH_GATHER;
          state_o.pending_kind = g_kind[1:0];
          state_o.bytes_left   = {28'd0, g_count};
          state_o.gathered     = 64'd0;
        end
      end

      if (do_finish) begin
        // nonempty str or bin continues with its payload
        if ((fin_kind == KIND_STR || fin_kind == KIND_BIN) && fin_value != 64'd0) begin
          if (fend) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            state_o.phase      = PH_PAYLOAD;
            state_o.bytes_left = fin_value[31:0];
          end
        end else begin
          state_o.phase      = PH_TYPE;
          state_o.bytes_left = 32'd0;
        end
        state_o.gathered  = 64'd0;
        res_valid_o       = 1'b1;
        res_o.token_kind  = fin_kind;
        res_o.token_value = fin_value;
      end

      if (do_fail) begin
        state_o          = TOK_STATE_RESET;
        state_o.dropping = !fend;
        res_valid_o      = 1'b1;
        res_o            = '{token_kind: KIND_ERROR, token_value: 64'd0, payload_last: 1'b0,
                             error_code: fail_code};
      end
    end
  end

endmodule

[sv/msgpack_subset_tokenizer.sv]
// Byte-serial msgpack subset tokenizer. Takes one frame byte per clock and gives at most
// one token word per byte: uint, map, str and bin headers once their big-endian length or
// value bytes are in, nil, bool, one word per str/bin payload byte (last one flagged), and
// an error word for an unsupported type byte or a frame that ends inside an item, after
// which the rest of the frame is dropped. Each byte goes from an input register through
// one step of decode logic into an output register, from which its result is offered,
// and the block sustains one byte per clock as long as the output side takes words.
// Map entry counting is left to the consumer.
module msgpack_subset_tokenizer
  import msgpk_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic       in_valid_q;
  in_word_t   in_word_q;
  tok_state_t state_q, state_d;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_word_q;
  logic       res_valid;
  out_word_t  res;
  logic       out_free;
  logic       step_fire;

  msgpk_step u_step (
    .state_i     (state_q),
    .word_i      (in_word_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign step_fire  = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || step_fire;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= TOK_STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step_fire) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
    if (step_fire && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
